// ===== sv/ipatp_pkg.sv =====
// ----------------------------------------------------------------------------
// ipatp_pkg
// Shared types, constants and character helpers for the address text parser.
// ----------------------------------------------------------------------------
package ipatp_pkg;

  // Default longest accepted IPv6 text
  localparam int DEF_MAX_TEXT_LEN = 45;

  // Length of the "::ffff:" prefix of the IPv4-mapped form
  localparam int MAPPED_PREFIX_LEN = 7;

  // Number of 16-bit groups in an IPv6 address
  localparam int HEX_GROUPS = 8;

  // Largest value of one dotted octet
  localparam int OCTET_MAX = 255;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Result classification
  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_IPV4    = 2'd1,
    KIND_IPV6    = 2'd2
  } kind_t;

  // Outcome of one dotted-quad parser
  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } dotted_res_t;

  // Character expected at each place of the mapped prefix
  function automatic logic [7:0] mapped_prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd2, 3'd3, 3'd4, 3'd5: ch = 8'h66;
      default:                ch = CH_COLON;
    endcase
    return ch;
  endfunction

  // Hex digit value; bit 4 set means the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      v = {1'b0, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      v = {1'b0, ch[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

// ===== sv/ipatp_char_if.sv =====
// ----------------------------------------------------------------------------
// ipatp_char_if
// Character channel: one text character per word, with an end-of-string flag.
// ----------------------------------------------------------------------------
interface ipatp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       is_last;

  modport source (output valid, output text_char, output is_last, input ready);
  modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

// ===== sv/ipatp_addr_if.sv =====
// ----------------------------------------------------------------------------
// ipatp_addr_if
// Result channel: classification and 128-bit address, one word per string.
// ----------------------------------------------------------------------------
interface ipatp_addr_if;
  logic                  valid;
  logic                  ready;
  ipatp_pkg::kind_t      addr_kind;
  logic [63:0]           addr_high;
  logic [63:0]           addr_low;

  modport source (output valid, output addr_kind, output addr_high, output addr_low,
                  input ready);
  modport sink   (input valid, input addr_kind, input addr_high, input addr_low,
                  output ready);
endinterface

// ===== sv/ipatp_dotted.sv =====
// ----------------------------------------------------------------------------
// ipatp_dotted
// Dotted-quad IPv4 parser, one character per cycle while feed is high, with an end-of-string view.
// ----------------------------------------------------------------------------
module ipatp_dotted (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   feed,
  input  logic                   clear,
  input  logic [7:0]             ch,
  output ipatp_pkg::dotted_res_t res
);

  logic [7:0]  value;
  logic [7:0]  octets [3];
  logic [1:0]  progress;
  logic        digit_seen;
  logic        ok;

  logic [7:0]  value_next;
  logic [7:0]  octets_next [3];
  logic [1:0]  progress_next;
  logic        digit_seen_next;
  logic        ok_next;
  logic [11:0] acc;

  // Advance the octet parse by one character
  always_comb begin
    acc             = 12'(value) * 12'd10 + 12'(ch - ipatp_pkg::CH_ZERO);
    value_next      = value;
    octets_next     = octets;
    progress_next   = progress;
    digit_seen_next = digit_seen;
    ok_next         = ok;
    if (feed && ok) begin
      if (ch >= ipatp_pkg::CH_ZERO && ch <= ipatp_pkg::CH_NINE) begin
        if (acc > 12'(ipatp_pkg::OCTET_MAX)) begin
          ok_next = 1'b0;
        end else begin
          value_next      = acc[7:0];
          digit_seen_next = 1'b1;
        end
      end else if (ch == ipatp_pkg::CH_DOT) begin
        if (!digit_seen || progress == 2'd3) begin
          ok_next = 1'b0;
        end else begin
          for (int j = 0; j < 3; j++) begin
            if (progress == 2'(j)) begin
              octets_next[j] = value;
            end
          end
          progress_next   = progress + 2'd1;
          value_next      = '0;
          digit_seen_next = 1'b0;
        end
      end else begin
        ok_next = 1'b0;
      end
    end
  end

  // Report the quad as it stands after this character
  assign res.ok   = ok_next && digit_seen_next && (progress_next == 2'd3);
  assign res.addr = {octets_next[0], octets_next[1], octets_next[2], value_next};

  // Hold the parse; drop it back to empty at the end of a string
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      value      <= '0;
      octets     <= '{default: '0};
      progress   <= '0;
      digit_seen <= 1'b0;
      ok         <= 1'b1;
    end else begin
      value      <= value_next;
      octets     <= octets_next;
      progress   <= progress_next;
      digit_seen <= digit_seen_next;
      ok         <= ok_next;
    end
  end

endmodule

// ===== sv/ip_address_text_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ip_address_text_parser_unit
// Streams address text one character per word and classifies it as IPv4,
// IPv6 (including the IPv4-mapped form) or invalid.
// ----------------------------------------------------------------------------
// Takes one character per cycle with no gaps needed between strings. Each
// character is captured in an input register and folded into the parse
// state at the clock edge on which it leaves that register. The word flagged
// is_last loads a single result word into the result register at that same
// edge, so a result passes the input register and then the result register.
// The result register holds one word: while it waits to be taken, characters
// of the next string keep flowing and only that string's last character is
// held back. Strings longer than MAX_TEXT_LEN characters are invalid unless
// they are dotted IPv4 text.
module ip_address_text_parser_unit #(
  parameter int MAX_TEXT_LEN = ipatp_pkg::DEF_MAX_TEXT_LEN
) (
  input  logic           clk,
  input  logic           rst,
  ipatp_char_if.sink     chars,
  ipatp_addr_if.source   result
);

  localparam int CountW = $clog2(MAX_TEXT_LEN + 2);

  // Input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       step;
  logic       clear;

  // Parse state
  logic [CountW-1:0] char_count;
  logic [CountW-1:0] char_count_next;
  logic              prefix_match;
  logic              prefix_match_next;
  logic              in_prefix;

  logic [15:0] groups [ipatp_pkg::HEX_GROUPS];
  logic [15:0] groups_next [ipatp_pkg::HEX_GROUPS];
  logic [15:0] group_value;
  logic [15:0] group_value_next;
  logic [3:0]  group_total;
  logic [3:0]  group_total_next;
  logic [3:0]  group_trailing;
  logic [3:0]  group_trailing_next;
  logic        hx_pending, hx_pending_next;
  logic        hx_prev_colon, hx_prev_colon_next;
  logic        hx_gap_seen, hx_gap_seen_next;
  logic        hx_done, hx_done_next;
  logic        hx_bad, hx_bad_next;

  logic [4:0]  dig;
  logic        is_hex;
  logic        hx_active;
  logic        close_now;

  // Result assembly
  ipatp_pkg::dotted_res_t whole_res;
  ipatp_pkg::dotted_res_t mapped_res;
  logic [15:0]      expanded [ipatp_pkg::HEX_GROUPS];
  logic [3:0]       before_cnt;
  logic [2:0]       src_idx;
  ipatp_pkg::kind_t kind_calc;
  logic [63:0]      high_calc;
  logic [63:0]      low_calc;

  // Result register
  logic             res_valid;
  ipatp_pkg::kind_t res_kind;
  logic [63:0]      res_high;
  logic [63:0]      res_low;

  // Handshake: only a last character waits for the result register
  assign step        = in_valid && (!in_last || !res_valid || result.ready);
  assign clear       = step && in_last;
  assign chars.ready = !in_valid || step;

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char <= chars.text_char;
      in_last <= chars.is_last;
    end
  end

  // Length count and mapped prefix check
  always_comb begin
    in_prefix         = char_count < CountW'(ipatp_pkg::MAPPED_PREFIX_LEN);
    char_count_next   = char_count;
    prefix_match_next = prefix_match;
    if (step) begin
      if (char_count < CountW'(MAX_TEXT_LEN + 1)) begin
        char_count_next = char_count + CountW'(1);
      end
      if (in_prefix && in_char != ipatp_pkg::mapped_prefix_char(char_count[2:0])) begin
        prefix_match_next = 1'b0;
      end
    end
  end

  // Dotted parsers over the whole text and over the text after the prefix
  ipatp_dotted u_whole (
    .clk   (clk),
    .rst   (rst),
    .feed  (step),
    .clear (clear),
    .ch    (in_char),
    .res   (whole_res)
  );

  ipatp_dotted u_mapped (
    .clk   (clk),
    .rst   (rst),
    .feed  (step && !in_prefix),
    .clear (clear),
    .ch    (in_char),
    .res   (mapped_res)
  );

  // Hex group parse; a group closes on a non-hex character or at end of text
  always_comb begin
    dig                 = ipatp_pkg::hex_value(in_char);
    is_hex              = !dig[4];
    hx_active           = step && !hx_done && !hx_bad;
    group_value_next    = group_value;
    group_total_next    = group_total;
    group_trailing_next = group_trailing;
    hx_pending_next     = hx_pending;
    hx_prev_colon_next  = hx_prev_colon;
    hx_gap_seen_next    = hx_gap_seen;
    hx_done_next        = hx_done;
    hx_bad_next         = hx_bad;
    if (hx_active && is_hex) begin
      group_value_next   = {group_value[11:0], dig[3:0]};
      hx_pending_next    = 1'b1;
      hx_prev_colon_next = 1'b0;
    end
    close_now = hx_active && hx_pending_next && (!is_hex || in_last);
    for (int j = 0; j < ipatp_pkg::HEX_GROUPS; j++) begin
      groups_next[j] = (close_now && group_total[2:0] == 3'(j)) ? group_value_next
                                                                 : groups[j];
    end
    if (close_now) begin
      group_total_next = group_total + 4'd1;
      if (hx_gap_seen) begin
        group_trailing_next = group_trailing + 4'd1;
      end
      hx_pending_next  = 1'b0;
      group_value_next = '0;
      if (group_total_next == 4'(ipatp_pkg::HEX_GROUPS)) begin
        hx_done_next = 1'b1;
      end
    end
    if (hx_active && !is_hex && !hx_done_next) begin
      if (in_char == ipatp_pkg::CH_COLON) begin
        if (hx_prev_colon) begin
          hx_gap_seen_next = 1'b1;
        end
        hx_prev_colon_next = 1'b1;
      end else begin
        hx_bad_next = 1'b1;
      end
    end
  end

  // Expand the gap: leading groups stay, trailing groups move to the end
  always_comb begin
    before_cnt = group_total_next - group_trailing_next;
    for (int j = 0; j < ipatp_pkg::HEX_GROUPS; j++) begin
      src_idx = 3'(j) + group_total_next[2:0];
      if (4'(j) < before_cnt) begin
        expanded[j] = groups_next[j];
      end else if (4'(j) >= 4'(ipatp_pkg::HEX_GROUPS) - group_trailing_next) begin
        expanded[j] = groups_next[src_idx];
      end else begin
        expanded[j] = '0;
      end
    end
  end

  // Classify the finished string
  always_comb begin
    kind_calc = ipatp_pkg::KIND_INVALID;
    high_calc = '0;
    low_calc  = '0;
    priority if (whole_res.ok) begin
      kind_calc = ipatp_pkg::KIND_IPV4;
      low_calc  = {32'd0, whole_res.addr};
    end else if (char_count_next <= CountW'(MAX_TEXT_LEN)) begin
      if (char_count_next > CountW'(ipatp_pkg::MAPPED_PREFIX_LEN) && prefix_match_next) begin
        if (mapped_res.ok) begin
          kind_calc = ipatp_pkg::KIND_IPV6;
          low_calc  = {16'd0, 16'hffff, mapped_res.addr};
        end
      end else if (!hx_bad_next &&
                   (hx_gap_seen_next || group_total_next == 4'(ipatp_pkg::HEX_GROUPS))) begin
        kind_calc = ipatp_pkg::KIND_IPV6;
        high_calc = {expanded[0], expanded[1], expanded[2], expanded[3]};
        low_calc  = {expanded[4], expanded[5], expanded[6], expanded[7]};
      end
    end else begin
      // Too long for IPv6: leave it invalid
      kind_calc = ipatp_pkg::KIND_INVALID;
    end
  end

  // Advance the parse state; drop it to empty after each string
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      char_count     <= '0;
      prefix_match   <= 1'b1;
      groups         <= '{default: '0};
      group_value    <= '0;
      group_total    <= '0;
      group_trailing <= '0;
      hx_pending     <= 1'b0;
      hx_prev_colon  <= 1'b0;
      hx_gap_seen    <= 1'b0;
      hx_done        <= 1'b0;
      hx_bad         <= 1'b0;
    end else begin
      char_count     <= char_count_next;
      prefix_match   <= prefix_match_next;
      groups         <= groups_next;
      group_value    <= group_value_next;
      group_total    <= group_total_next;
      group_trailing <= group_trailing_next;
      hx_pending     <= hx_pending_next;
      hx_prev_colon  <= hx_prev_colon_next;
      hx_gap_seen    <= hx_gap_seen_next;
      hx_done        <= hx_done_next;
      hx_bad         <= hx_bad_next;
    end
  end

  // Result register: load on the last character, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (clear) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      res_kind <= kind_calc;
      res_high <= high_calc;
      res_low  <= low_calc;
    end
  end

  assign result.valid     = res_valid;
  assign result.addr_kind = res_kind;
  assign result.addr_high = res_high;
  assign result.addr_low  = res_low;

endmodule

// ===== dv/ip_address_text_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_address_text_parser_unit_tb
// Streams address strings into the parser one character per word and checks
// every result word against a cycle-free model of the classification rules.
// Directed strings cover the boundary cases; random strings mix well-formed
// IPv4, full and compressed IPv6, mapped forms, mutations and noise.
// ----------------------------------------------------------------------------
module ip_address_text_parser_unit_tb;
  import ipatp_pkg::*;

  localparam string MAPPED_TEXT   = "::ffff:";
  localparam string NOISE_ALPHA   = "0123456789abcdefABCDEF.:";
  localparam int    HOLD_CYCLES   = 200;
  localparam int    RAND_CHARS    = 180;
  localparam int    RAND_STRINGS  = 12;
  localparam int    QUIET_CHARS   = 140;

  // Running state of one dotted-quad parse
  typedef struct packed {
    bit [8:0]      value;
    bit [3:0][7:0] octets;
    bit [2:0]      progress;
    bit            digit_seen;
    bit            ok;
  } quad_parse_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] high;
    logic [63:0] low;
  } addr_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the result of each string and checks result words
  // --------------------------------------------------------------------------
  class addr_text_scoreboard;
    addr_word_t  expected_words[$];
    int unsigned mismatches;
    int unsigned seen_v4, seen_v6, seen_invalid;

    int unsigned text_len;
    quad_parse_t whole_quad, tail_quad;
    bit          prefix_ok;
    bit [15:0]   groups[HEX_GROUPS];
    bit [15:0]   cur_group;
    int unsigned groups_total, groups_after_gap;
    bit          digit_pending, prev_colon, gap_seen, groups_full, hex_rejected;

    function new();
      clear_parse();
    endfunction

    function void clear_parse();
      text_len         = 0;
      whole_quad       = '0;
      whole_quad.ok    = 1'b1;
      tail_quad        = whole_quad;
      prefix_ok        = 1'b1;
      foreach (groups[i]) groups[i] = '0;
      cur_group        = '0;
      groups_total     = 0;
      groups_after_gap = 0;
      digit_pending    = 1'b0;
      prev_colon       = 1'b0;
      gap_seen         = 1'b0;
      groups_full      = 1'b0;
      hex_rejected     = 1'b0;
    endfunction

    function quad_parse_t quad_feed(quad_parse_t p, bit [7:0] ch);
      int unsigned v;
      if (!p.ok) return p;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        v = int'(p.value) * 10 + int'(ch) - int'(CH_ZERO);
        if (v > OCTET_MAX) begin
          p.ok = 1'b0;
        end else begin
          p.value      = v[8:0];
          p.digit_seen = 1'b1;
        end
      end else if (ch == CH_DOT) begin
        if (!p.digit_seen || p.progress >= 3) begin
          p.ok = 1'b0;
        end else begin
          p.octets[p.progress[1:0]] = p.value[7:0];
          p.progress   = p.progress + 1;
          p.value      = '0;
          p.digit_seen = 1'b0;
        end
      end else begin
        p.ok = 1'b0;
      end
      return p;
    endfunction

    function bit quad_done(quad_parse_t p, output bit [31:0] addr);
      addr = {p.octets[0], p.octets[1], p.octets[2], p.value[7:0]};
      return p.ok && p.digit_seen && p.progress == 3;
    endfunction

    function int unsigned hex_digit(bit [7:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return 32'(ch - CH_ZERO);
      if (ch >= "a" && ch <= "f") return ch - "a" + 10;
      if (ch >= "A" && ch <= "F") return ch - "A" + 10;
      return 16;
    endfunction

    function void close_group();
      if (!digit_pending) return;
      groups[groups_total % HEX_GROUPS] = cur_group;
      groups_total++;
      if (gap_seen) groups_after_gap++;
      digit_pending = 1'b0;
      cur_group     = '0;
      if (groups_total >= HEX_GROUPS) groups_full = 1'b1;
    endfunction

    function void hex_feed(bit [7:0] ch);
      int unsigned d;
      if (groups_full || hex_rejected) return;
      d = hex_digit(ch);
      if (d < 16) begin
        cur_group     = {cur_group[11:0], d[3:0]};
        digit_pending = 1'b1;
        prev_colon    = 1'b0;
        return;
      end
      close_group();
      if (groups_full) return;
      if (ch == CH_COLON) begin
        if (prev_colon) gap_seen = 1'b1;
        prev_colon = 1'b1;
      end else begin
        hex_rejected = 1'b1;
      end
    endfunction

    // Fold one accepted character in; on the last one, queue the expected word
    function void note_char(bit [7:0] ch, bit last);
      int unsigned idx, total, trail, lead;
      bit [31:0]   v4;
      bit [15:0]   g[HEX_GROUPS];
      addr_word_t  w;
      idx = text_len;
      if (text_len < DEF_MAX_TEXT_LEN + 1) text_len++;
      whole_quad = quad_feed(whole_quad, ch);
      if (idx < MAPPED_PREFIX_LEN) begin
        if (ch != MAPPED_TEXT[idx]) prefix_ok = 1'b0;
      end else begin
        tail_quad = quad_feed(tail_quad, ch);
      end
      hex_feed(ch);
      if (!last) return;

      if (!groups_full && !hex_rejected) close_group();
      w = '{kind: KIND_INVALID, high: '0, low: '0};
      if (quad_done(whole_quad, v4)) begin
        w.kind = KIND_IPV4;
        w.low  = {32'h0, v4};
      end else if (text_len <= DEF_MAX_TEXT_LEN) begin
        if (text_len > MAPPED_PREFIX_LEN && prefix_ok) begin
          if (quad_done(tail_quad, v4)) begin
            w.kind = KIND_IPV6;
            w.low  = {16'h0, 16'hffff, v4};
          end
        end else if (!hex_rejected && (gap_seen || groups_total == HEX_GROUPS)) begin
          // Place leading groups first, trailing groups at the end, zeros between
          total = groups_total > HEX_GROUPS ? HEX_GROUPS : groups_total;
          trail = groups_after_gap > total ? total : groups_after_gap;
          lead  = total - trail;
          foreach (g[i]) g[i] = '0;
          for (int i = 0; i < lead; i++) g[i] = groups[i];
          for (int i = 0; i < trail; i++) g[HEX_GROUPS - trail + i] = groups[lead + i];
          w.kind = KIND_IPV6;
          w.high = {g[0], g[1], g[2], g[3]};
          w.low  = {g[4], g[5], g[6], g[7]};
        end
      end
      expected_words.insert(expected_words.size(), w);
      clear_parse();
    endfunction

    function void check_word(kind_t kind, logic [63:0] high, logic [63:0] low);
      addr_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with no string pending: kind %0d high %h low %h",
               kind, high, low);
        mismatches++;
        return;
      end
      w = expected_words.pop_front();
      case (w.kind)
        KIND_IPV4: seen_v4++;
        KIND_IPV6: seen_v6++;
        default:   seen_invalid++;
      endcase
      if (kind !== w.kind) begin
        $error("addr_kind mismatch: expected %0d, actual %0d", w.kind, kind);
        mismatches++;
      end
      if (high !== w.high) begin
        $error("addr_high mismatch: expected %h, actual %h", w.high, high);
        mismatches++;
      end
      if (low !== w.low) begin
        $error("addr_low mismatch: expected %h, actual %h", w.low, low);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ipatp_char_if chars_if();
  ipatp_addr_if addr_if();

  ip_address_text_parser_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (addr_if)
  );

  addr_text_scoreboard sb = new();

  bit [7:0]    text_buf[$];
  bit          gaps_on  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned chars_sent, strings_sent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Text builders
  // --------------------------------------------------------------------------
  // Append one character to the string being built
  function automatic void put_char(bit [7:0] ch);
    text_buf.insert(text_buf.size(), ch);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void push_dec(int unsigned value, int unsigned zeros);
    repeat (zeros) put_char(CH_ZERO);
    push_str($sformatf("%0d", value));
  endfunction

  function automatic bit [7:0] noise_char();
    if ($urandom_range(0, 1) == 0) return NOISE_ALPHA[$urandom_range(0, NOISE_ALPHA.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_hex_group();
    int unsigned ndig, d;
    ndig = $urandom_range(0, 15) == 0 ? $urandom_range(5, 8) : $urandom_range(1, 4);
    repeat (ndig) begin
      d = $urandom_range(0, 15);
      if (d < 10)                         put_char(8'(CH_ZERO + d));
      else if ($urandom_range(0, 1) == 0) put_char(8'("a" + d - 10));
      else                                put_char(8'("A" + d - 10));
    end
  endfunction

  function automatic void push_hex_groups(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put_char(CH_COLON);
      push_hex_group();
    end
  endfunction

  function automatic void gen_dotted();
    int unsigned n, r, value, zeros;
    r = $urandom_range(0, 19);
    n = r == 0 ? 3 : (r == 1 ? 5 : 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put_char(CH_DOT);
      if ($urandom_range(0, 39) != 0) begin
        value = $urandom_range(0, 19) == 0 ? $urandom_range(256, 999) : $urandom_range(0, 255);
        zeros = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0;
        if ($urandom_range(0, 49) == 0) zeros = $urandom_range(10, 20);
        push_dec(value, zeros);
      end
    end
  endfunction

  function automatic void gen_hex_full();
    int unsigned pad;
    push_hex_groups(HEX_GROUPS);
    // Trail text after the eighth group, straddling the length limit
    if ($urandom_range(0, 3) == 0) begin
      pad = $urandom_range(0, 10);
      if (text_buf.size() < 40) pad += 40 - text_buf.size();
      put_char(CH_COLON);
      repeat (pad) put_char(noise_char());
    end
  endfunction

  function automatic void gen_hex_gap();
    int unsigned total, lead;
    total = $urandom_range(0, 7);
    lead  = $urandom_range(0, total);
    push_hex_groups(lead);
    put_char(CH_COLON);
    put_char(CH_COLON);
    push_hex_groups(total - lead);
    if ($urandom_range(0, 9) == 0) begin
      push_str("::");
      push_hex_group();
    end
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(1, 20)) put_char(noise_char());
  endfunction

  function automatic void mutate_text();
    int unsigned pos;
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 2))
      0: text_buf[pos] = noise_char();
      1: if (text_buf.size() > 1) text_buf.delete(pos);
      default: text_buf.insert(pos, noise_char());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_char(input bit [7:0] ch, input bit last);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.text_char <= ch;
    chars_if.is_last   <= last;
    do @(posedge clk); while (chars_if.ready !== 1'b1);
    sb.note_char(ch, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    if (text_buf.size() == 0) put_char(CH_ZERO);
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
    strings_sent++;
  endtask

  // Receiver: random stalls, plus the occasional long hold-off
  initial begin
    addr_if.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        addr_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        addr_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      addr_if.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Check each result word taken
  always @(posedge clk) begin
    if (!rst && addr_if.valid === 1'b1 && addr_if.ready === 1'b1) begin
      sb.check_word(addr_if.addr_kind, addr_if.addr_high, addr_if.addr_low);
    end
  end

  // Stimulus
  initial begin
    string       directed_texts[];
    int unsigned directed_chars, r;

    directed_texts = '{
      "0.0.0.0", "255.255.255.255", "256.1.1.1", "1.2.3", "1..2.3", "1.2.3.4.5",
      "::", "::1", "1::", "ffff:FFFF:0:0:0:0:0:1", "1:2:3:4:5:6:7",
      "1:2:3:4:5:6:7:8:garbage", "12345:1::", "1::2::3", "::ffff:192.168.1.1",
      "::ffff:1.2.3", "::ffff:", "1:2:3:g::", "::FFFF:1.2.3.4", "5", "x"
    };

    rst                <= 1'b1;
    chars_if.valid     <= 1'b0;
    chars_if.text_char <= '0;
    chars_if.is_last   <= 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed boundary strings
    foreach (directed_texts[i]) begin
      push_str(directed_texts[i]);
      send_text();
    end
    // Ignored tail reaching exactly the limit, then one past it
    push_str("1:2:3:4:5:6:7:8");
    repeat (DEF_MAX_TEXT_LEN - 15) put_char("x");
    send_text();
    push_str("1:2:3:4:5:6:7:8");
    repeat (DEF_MAX_TEXT_LEN - 14) put_char("x");
    send_text();
    // Dotted text far beyond the length counter's range stays valid
    push_dec(1, 60);
    push_str(".2.3.4");
    send_text();
    directed_chars = chars_sent;

    // Random strings, mostly well-formed
    for (int n = 0; chars_sent - directed_chars < RAND_CHARS || n < RAND_STRINGS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      gen_dotted();
      else if (r < 55) gen_hex_full();
      else if (r < 80) gen_hex_gap();
      else if (r < 90) begin
        push_str(MAPPED_TEXT);
        gen_dotted();
      end else         gen_noise();
      if (r < 90 && text_buf.size() > 0 && $urandom_range(0, 6) == 0) mutate_text();
      if (n == 3 || n == 9) hold_req = 1'b1;
      if (chars_sent - directed_chars >= QUIET_CHARS) gaps_on = 1'b0;
      send_text();
    end
    chars_if.valid <= 1'b0;

    // Drain and let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("stimulus: %0d strings, %0d characters, incl. two long result hold-offs",
             strings_sent, chars_sent);
    $display("results checked: %0d IPv4, %0d IPv6, %0d invalid",
             sb.seen_v4, sb.seen_v6, sb.seen_invalid);
    if (sb.mismatches == 0) begin
      $display("ip_address_text_parser_unit regression: pass");
    end else begin
      $display("ip_address_text_parser_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("timeout waiting for stimulus or results");
    $display("ip_address_text_parser_unit regression: fail");
    $finish;
  end

endmodule
